// File: rtl/ppft_pkg.sv
// shared constants and types for the planar pose frame transform
`default_nettype none
package ppft_pkg;

    localparam int CORDIC_STAGES  = 16;
    localparam int ATAN_TABLE_LEN = 24;
    localparam int NUM_ITER = (CORDIC_STAGES > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN : CORDIC_STAGES;

    localparam int POS_W     = 32;
    localparam int QUAT_W    = 16;
    localparam int ANGLE_W   = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int ROT_W     = 34;
    localparam int VEC_W     = 37;

    localparam logic [31:0] ATAN_TURNS [ATAN_TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic signed [ROT_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WORLD_OFFSET_X = 3'd0,
        REG_WORLD_OFFSET_Y = 3'd1,
        REG_WORLD_ROTATION = 3'd2,
        REG_MOUNT_OFFSET_X = 3'd3,
        REG_MOUNT_OFFSET_Y = 3'd4,
        REG_MOUNT_ROTATION = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] y;
        logic signed [ROT_W-1:0] z;
        logic                    neg;
    } rot_state_t;

endpackage
`default_nettype wire

// File: rtl/ppft_rot_cordic.sv
// pipelined rotation-mode cordic giving clamped q2.30 sine and cosine
`default_nettype none
module ppft_rot_cordic (
    input  logic               clk,
    input  logic               en,
    input  logic [31:0]        angle,
    output logic signed [31:0] sin_q30,
    output logic signed [31:0] cos_q30
);
    import ppft_pkg::*;

    localparam logic signed [ROT_W-1:0] ONE_Q30  = 34'sh040000000;
    localparam logic signed [ROT_W-1:0] HALF_TRN = 34'sh080000000;

    rot_state_t         stage_reg [0:NUM_ITER];
    rot_state_t         pre_next;
    logic signed [31:0] sin_next;
    logic signed [31:0] cos_next;
    logic signed [31:0] sin_reg;
    logic signed [31:0] cos_reg;

    function automatic rot_state_t rot_iter(rot_state_t s, int sh, logic [31:0] at);
        rot_state_t              r;
        logic signed [ROT_W-1:0] xs;
        logic signed [ROT_W-1:0] ys;
        logic signed [ROT_W-1:0] ae;
        xs = s.x >>> sh;
        ys = s.y >>> sh;
        ae = $signed({2'b00, at});
        r  = s;
        if (!s.z[ROT_W-1])
        begin
            r.x = s.x - ys;
            r.y = s.y + xs;
            r.z = s.z - ae;
        end
        else
        begin
            r.x = s.x + ys;
            r.y = s.y - xs;
            r.z = s.z + ae;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] clamp_q30(logic signed [ROT_W-1:0] v);
        logic signed [ROT_W-1:0] c;
        c = v;
        if (v > ONE_Q30)
        begin
            c = ONE_Q30;
        end
        else if (v < -ONE_Q30)
        begin
            c = -ONE_Q30;
        end
        return c[31:0];
    endfunction

    always_comb
    begin
        pre_next.x   = CORDIC_GAIN_Q30;
        pre_next.y   = '0;
        pre_next.z   = $signed({{2{angle[31]}}, angle});
        pre_next.neg = 1'b0;
        if (pre_next.z > ONE_Q30)
        begin
            pre_next.z   = pre_next.z - HALF_TRN;
            pre_next.neg = 1'b1;
        end
        else if (pre_next.z < -ONE_Q30)
        begin
            pre_next.z   = pre_next.z + HALF_TRN;
            pre_next.neg = 1'b1;
        end
    end

    always_comb
    begin
        if (stage_reg[NUM_ITER].neg)
        begin
            cos_next = clamp_q30(-stage_reg[NUM_ITER].x);
            sin_next = clamp_q30(-stage_reg[NUM_ITER].y);
        end
        else
        begin
            cos_next = clamp_q30(stage_reg[NUM_ITER].x);
            sin_next = clamp_q30(stage_reg[NUM_ITER].y);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= pre_next;
            sin_reg      <= sin_next;
            cos_reg      <= cos_next;
        end
    end

    for (genvar i = 0; i < NUM_ITER; i++)
    begin : g_iter
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                stage_reg[i+1] <= rot_iter(stage_reg[i], i, ATAN_TURNS[i]);
            end
        end
    end

    assign sin_q30 = sin_reg;
    assign cos_q30 = cos_reg;

endmodule
`default_nettype wire

// File: rtl/planar_pose_frame_transform.sv
// top level of the planar pose frame transform pipeline
// Usage:
//  in channel: pos_x/y/z and quat_x/y/z/w with in_valid; the block drives in_stall.
//  A transfer happens on a rising edge with in_valid high and in_stall low.
//  out channel: base_x/y/z and heading_sin_half/cos_half with out_valid; the
//  receiver drives out_stall, a transfer happens with out_valid high, out_stall low.
//  Config: cfg_write with cfg_index and cfg_data writes one register per edge;
//  write only while no pose is in flight.
//  Throughput: one pose per cycle while out_stall does not hold the output.
//  Pipeline depth is set by the yaw vectoring cordic followed by the heading
//  rotation cordic, each one iteration per stage, plus the multiply and sum
//  stages around them.
//  Reset clears all valid bits and sets every config register to zero.
//  While a result waits under out_stall the whole pipeline holds and in_stall
//  is raised; nothing is dropped or repeated.
`default_nettype none
module planar_pose_frame_transform (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_write,
    input  logic [ppft_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ppft_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [ppft_pkg::POS_W-1:0]     pos_x,
    input  logic signed [ppft_pkg::POS_W-1:0]     pos_y,
    input  logic signed [ppft_pkg::POS_W-1:0]     pos_z,
    input  logic signed [ppft_pkg::QUAT_W-1:0]    quat_x,
    input  logic signed [ppft_pkg::QUAT_W-1:0]    quat_y,
    input  logic signed [ppft_pkg::QUAT_W-1:0]    quat_z,
    input  logic signed [ppft_pkg::QUAT_W-1:0]    quat_w,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [ppft_pkg::POS_W-1:0]     base_x,
    output logic signed [ppft_pkg::POS_W-1:0]     base_y,
    output logic signed [ppft_pkg::POS_W-1:0]     base_z,
    output logic signed [ppft_pkg::QUAT_W-1:0]    heading_sin_half,
    output logic signed [ppft_pkg::QUAT_W-1:0]    heading_cos_half
);
    import ppft_pkg::*;

    localparam int S_YAW  = NUM_ITER + 4;
    localparam int S_WSUM = NUM_ITER + 6;
    localparam int LAT    = 2 * NUM_ITER + 8;

    typedef struct packed {
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [31:0]             ang;
        logic                    zero;
    } vec_state_t;

    typedef struct packed {
        logic signed [POS_W-1:0] a;
        logic signed [POS_W-1:0] b;
        logic signed [POS_W-1:0] z;
    } carry_t;

    logic signed [POS_W-1:0]   world_offset_x_reg;
    logic signed [POS_W-1:0]   world_offset_y_reg;
    logic [ANGLE_W-1:0]        world_rotation_reg;
    logic signed [POS_W-1:0]   mount_offset_x_reg;
    logic signed [POS_W-1:0]   mount_offset_y_reg;
    logic [ANGLE_W-1:0]        mount_rotation_reg;

    logic [LAT:1]              valid_reg;
    logic                      adv;

    carry_t                    carry_reg [1:LAT-1];
    logic signed [31:0]        pxy_reg, pwz_reg, pyy_reg, pzz_reg;
    logic signed [33:0]        num_reg, den_reg;
    logic signed [33:0]        num_next, den_next;
    vec_state_t                vec_reg [0:NUM_ITER];
    vec_state_t                vpre_next;
    logic [ANGLE_W-1:0]        body_hdg_reg, final_hdg_reg;
    logic [ANGLE_W-1:0]        raw_yaw, body_hdg_next;
    logic [31:0]               ang_round;
    logic signed [63:0]        wm_cx_reg, wm_sy_reg, wm_sx_reg, wm_cy_reg;
    logic signed [POS_W-1:0]   rx_next, ry_next;
    logic signed [63:0]        bm_cx_reg, bm_sy_reg, bm_sx_reg, bm_cy_reg;
    logic signed [QUAT_W-1:0]  hs_q_reg, hc_q_reg;
    logic signed [31:0]        wsin, wcos, bsin, bcos, hsin, hcos;

    logic signed [POS_W-1:0]   base_x_reg, base_y_reg, base_z_reg;
    logic signed [QUAT_W-1:0]  heading_sin_reg, heading_cos_reg;

    function automatic vec_state_t vec_iter(vec_state_t s, int sh, logic [31:0] at);
        vec_state_t              r;
        logic signed [VEC_W-1:0] xs;
        logic signed [VEC_W-1:0] ys;
        xs = s.x >>> sh;
        ys = s.y >>> sh;
        r  = s;
        if (!s.y[VEC_W-1])
        begin
            r.x   = s.x + ys;
            r.y   = s.y - xs;
            r.ang = s.ang + at;
        end
        else
        begin
            r.x   = s.x - ys;
            r.y   = s.y + xs;
            r.ang = s.ang - at;
        end
        return r;
    endfunction

    function automatic logic signed [31:0] round30(logic signed [63:0] s);
        logic signed [63:0] r;
        r = s + 64'sh20000000;
        return r[61:30];
    endfunction

    function automatic logic signed [15:0] to_q14(logic signed [31:0] v);
        logic signed [32:0] s;
        logic signed [16:0] r;
        s = 33'(v) + 33'sd32768;
        r = s[32:16];
        if (r > 17'sd16384)
        begin
            r = 17'sd16384;
        end
        else if (r < -17'sd16384)
        begin
            r = -17'sd16384;
        end
        return r[15:0];
    endfunction

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_offset_x_reg <= '0;
            world_offset_y_reg <= '0;
            world_rotation_reg <= '0;
            mount_offset_x_reg <= '0;
            mount_offset_y_reg <= '0;
            mount_rotation_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WORLD_OFFSET_X: world_offset_x_reg <= cfg_data;
                REG_WORLD_OFFSET_Y: world_offset_y_reg <= cfg_data;
                REG_WORLD_ROTATION: world_rotation_reg <= cfg_data[ANGLE_W-1:0];
                REG_MOUNT_OFFSET_X: mount_offset_x_reg <= cfg_data;
                REG_MOUNT_OFFSET_Y: mount_offset_y_reg <= cfg_data;
                REG_MOUNT_ROTATION: mount_rotation_reg <= cfg_data[ANGLE_W-1:0];
                default:            ;
            endcase
        end
    end

    // pipeline advances unless a result is held at the output
    assign adv      = !(valid_reg[LAT] && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[LAT-1:1], in_valid};
        end
    end

    // orientation sums and vectoring entry
    always_comb
    begin
        num_next = (34'(pxy_reg) + 34'(pwz_reg)) <<< 1;
        den_next = 34'sh010000000 - ((34'(pyy_reg) + 34'(pzz_reg)) <<< 1);

        vpre_next.x    = VEC_W'(den_reg);
        vpre_next.y    = VEC_W'(num_reg);
        vpre_next.ang  = '0;
        vpre_next.zero = (den_reg == '0) && (num_reg == '0);
        if (den_reg[33])
        begin
            vpre_next.x   = -VEC_W'(den_reg);
            vpre_next.y   = -VEC_W'(num_reg);
            vpre_next.ang = 32'h80000000;
        end
    end

    // yaw rounding and angle sums
    always_comb
    begin
        ang_round     = vec_reg[NUM_ITER].ang + 32'h00008000;
        raw_yaw       = vec_reg[NUM_ITER].zero ? '0 : ang_round[31:16];
        body_hdg_next = world_rotation_reg + raw_yaw;
    end

    assign rx_next = world_offset_x_reg + round30(wm_cx_reg - wm_sy_reg);
    assign ry_next = world_offset_y_reg + round30(wm_sx_reg + wm_cy_reg);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pxy_reg <= quat_x * quat_y;
            pwz_reg <= quat_w * quat_z;
            pyy_reg <= quat_y * quat_y;
            pzz_reg <= quat_z * quat_z;

            num_reg <= num_next;
            den_reg <= den_next;

            vec_reg[0] <= vpre_next;

            body_hdg_reg  <= body_hdg_next;
            final_hdg_reg <= body_hdg_next + mount_rotation_reg;

            wm_cx_reg <= wcos * carry_reg[S_YAW].a;
            wm_sy_reg <= wsin * carry_reg[S_YAW].b;
            wm_sx_reg <= wsin * carry_reg[S_YAW].a;
            wm_cy_reg <= wcos * carry_reg[S_YAW].b;

            bm_cx_reg <= bcos * mount_offset_x_reg;
            bm_sy_reg <= bsin * mount_offset_y_reg;
            bm_sx_reg <= bsin * mount_offset_x_reg;
            bm_cy_reg <= bcos * mount_offset_y_reg;
            hs_q_reg  <= to_q14(hsin);
            hc_q_reg  <= to_q14(hcos);

            base_x_reg      <= carry_reg[LAT-1].a + round30(bm_cx_reg - bm_sy_reg);
            base_y_reg      <= carry_reg[LAT-1].b + round30(bm_sx_reg + bm_cy_reg);
            base_z_reg      <= carry_reg[LAT-1].z;
            heading_sin_reg <= hs_q_reg;
            heading_cos_reg <= hc_q_reg;
        end
    end

    for (genvar i = 0; i < NUM_ITER; i++)
    begin : g_vec
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                vec_reg[i+1] <= vec_iter(vec_reg[i], i, ATAN_TURNS[i]);
            end
        end
    end

    // position carry line, replaced by the world-frame position after the world sum
    for (genvar k = 1; k < LAT; k++)
    begin : g_carry
        if (k == 1)
        begin : g_first
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    carry_reg[k] <= '{a: pos_x, b: pos_y, z: pos_z};
                end
            end
        end
        else if (k == S_WSUM)
        begin : g_world
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    carry_reg[k] <= '{a: rx_next, b: ry_next, z: carry_reg[k-1].z};
                end
            end
        end
        else
        begin : g_pass
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    carry_reg[k] <= carry_reg[k-1];
                end
            end
        end
    end

    ppft_rot_cordic u_world_cordic (
        .clk     (clk),
        .en      (adv),
        .angle   ({world_rotation_reg, 16'h0000}),
        .sin_q30 (wsin),
        .cos_q30 (wcos)
    );

    ppft_rot_cordic u_rigid_cordic (
        .clk     (clk),
        .en      (adv),
        .angle   ({body_hdg_reg, 16'h0000}),
        .sin_q30 (bsin),
        .cos_q30 (bcos)
    );

    ppft_rot_cordic u_head_cordic (
        .clk     (clk),
        .en      (adv),
        .angle   ({final_hdg_reg[15], final_hdg_reg, 15'h0000}),
        .sin_q30 (hsin),
        .cos_q30 (hcos)
    );

    assign out_valid        = valid_reg[LAT];
    assign base_x           = base_x_reg;
    assign base_y           = base_y_reg;
    assign base_z           = base_z_reg;
    assign heading_sin_half = heading_sin_reg;
    assign heading_cos_half = heading_cos_reg;

`ifndef SYNTHESIS
    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAT] && out_stall) |=> $stable(valid_reg))
        else $error("valid bits moved while output held");

    a_entry_capture: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |=> (valid_reg[1] == $past(in_valid)))
        else $error("first stage valid does not follow accepted transfer");

    a_drain_to_output: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[LAT-1] && !in_stall) |=> out_valid)
        else $error("item lost before output stage");

    a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (heading_sin_half >= -16'sd16384 && heading_sin_half <= 16'sd16384
                       && heading_cos_half >= -16'sd16384 && heading_cos_half <= 16'sd16384))
        else $error("heading quaternion out of range");
`endif

endmodule
`default_nettype wire
